FILE: rtl/u8dw_pkg.sv
package u8dw_pkg;

    localparam int COUNT_BITS = 16;
    localparam int SUM_BITS   = COUNT_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] TILDE_BYTE = 8'h7E;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic       fire;
        logic       last;
        logic [1:0] cols;
    } step_t;

    function automatic logic [1:0] needed_after(input logic [7:0] b);
        logic [1:0] n;
        if (b[7:5] == 3'b110) begin
            n = 2'd1;
        end
        else if (b[7:4] == 4'b1110) begin
            n = 2'd2;
        end
        else if (b[7:3] == 5'b11110) begin
            n = 2'd3;
        end
        else begin
            n = 2'd0;
        end
        return n;
    endfunction

    function automatic logic [4:0] lead_bits(input logic [7:0] b, input logic [1:0] need);
        logic [4:0] v;
        case (need)
            2'd1:    v = b[4:0];
            2'd2:    v = {1'b0, b[3:0]};
            default: v = {2'b00, b[2:0]};
        endcase
        return v;
    endfunction

    function automatic logic is_term(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A))
            || (b == TILDE_BYTE);
    endfunction

    function automatic logic [1:0] cols_of(input logic [20:0] cp);
        logic [1:0] w;
        if ((cp < 21'h20) || ((cp >= 21'h7F) && (cp < 21'hA0))) begin
            w = 2'd0;
        end
        else if (((cp >= 21'h200B) && (cp <= 21'h200D))
              || ((cp >= 21'hFE00) && (cp <= 21'hFE0F))
              || ((cp >= 21'h0300) && (cp <= 21'h036F))
              || ((cp >= 21'h1AB0) && (cp <= 21'h1AFF))
              || ((cp >= 21'h1DC0) && (cp <= 21'h1DFF))
              || ((cp >= 21'h20D0) && (cp <= 21'h20FF))
              || ((cp >= 21'hFE20) && (cp <= 21'hFE2F))) begin
            w = 2'd0;
        end
        else if ((cp >= 21'h1F300) && (cp <= 21'h1FAFF)) begin
            w = 2'd2;
        end
        else if ((cp >= 21'h2600) && (cp <= 21'h27BF)) begin
            w = 2'd1;
        end
        else if (((cp >= 21'h1100) && (cp <= 21'h115F))
              || ((cp >= 21'h2E80) && (cp <= 21'hA4CF) && (cp != 21'h303F))
              || ((cp >= 21'hAC00) && (cp <= 21'hD7A3))
              || ((cp >= 21'hF900) && (cp <= 21'hFAFF))
              || ((cp >= 21'hFE10) && (cp <= 21'hFE19))
              || ((cp >= 21'hFE30) && (cp <= 21'hFE6F))
              || ((cp >= 21'hFF00) && (cp <= 21'hFF60))
              || ((cp >= 21'hFFE0) && (cp <= 21'hFFE6))
              || ((cp >= 21'h20000) && (cp <= 21'h2FFFD))
              || ((cp >= 21'h30000) && (cp <= 21'h3FFFD))) begin
            w = 2'd2;
        end
        else begin
            w = 2'd1;
        end
        return w;
    endfunction

    function automatic logic [1:0] cols_of_byte(input logic [7:0] b);
        return cols_of({13'b0, b});
    endfunction

endpackage

FILE: rtl/u8dw_decode.sv
module u8dw_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  u8dw_pkg::beat_t beat,
    output u8dw_pkg::step_t step
);
    import u8dw_pkg::*;

    logic        esc_reg;
    logic        esc_next;
    logic [1:0]  need_reg;
    logic [1:0]  need_next;
    logic [7:0]  lead_reg;
    logic [7:0]  lead_next;
    logic [7:0]  held1_reg;
    logic [7:0]  held1_next;
    logic [7:0]  held2_reg;
    logic [7:0]  held2_next;
    logic [20:0] cp_reg;
    logic [20:0] cp_next;

    logic [7:0]  b;
    logic [1:0]  total;
    logic [1:0]  got;
    logic [1:0]  nb;
    logic [1:0]  main_cols;
    logic [1:0]  tail_total;
    logic [1:0]  tail_n;
    logic [1:0]  tail_cols;
    logic [1:0]  t1;
    logic [1:0]  t2;

    assign b = beat.data;

    always_comb
    begin
        esc_next   = esc_reg;
        need_next  = need_reg;
        lead_next  = lead_reg;
        held1_next = held1_reg;
        held2_next = held2_reg;
        cp_next    = cp_reg;
        main_cols  = 2'd0;
        total      = needed_after(lead_reg);
        got        = 2'(total + 2'd1 - need_reg);
        nb         = needed_after(b);

        if (need_reg != 2'd0)
        begin
            if (got == 2'd1)
            begin
                held1_next = b;
            end
            else if (got == 2'd2)
            begin
                held2_next = b;
            end
            cp_next   = {cp_reg[14:0], b[5:0]};
            need_next = need_reg - 2'd1;
            if (need_next == 2'd0)
            begin
                main_cols = cols_of(cp_next);
            end
        end
        else if (esc_reg)
        begin
            if (is_term(b))
            begin
                esc_next = 1'b0;
            end
        end
        else if (b == ESC_BYTE)
        begin
            esc_next = 1'b1;
        end
        else if (nb != 2'd0)
        begin
            need_next = nb;
            cp_next   = {16'b0, lead_bits(b, nb)};
            lead_next = b;
        end
        else
        begin
            main_cols = cols_of_byte(b);
        end

        // A cut-off sequence: the lead byte counts one column and the bytes held
        // after it are scanned again from a clean state.
        tail_total = needed_after(lead_next);
        tail_n     = 2'(tail_total + 2'd1 - need_next);
        t1         = (held1_next == ESC_BYTE) ? 2'd0 : cols_of_byte(held1_next);
        t2         = (held2_next == ESC_BYTE) ? 2'd0 : cols_of_byte(held2_next);
        case (tail_n)
            2'd2:
            begin
                tail_cols = 2'd1 + t1;
            end
            2'd3:
            begin
                if (held1_next == ESC_BYTE)
                begin
                    tail_cols = 2'd1;
                end
                else if (needed_after(held1_next) == 2'd1)
                begin
                    tail_cols = 2'd1 + cols_of({10'b0, held1_next[4:0], held2_next[5:0]});
                end
                else
                begin
                    tail_cols = 2'd1 + t1 + t2;
                end
            end
            default:
            begin
                tail_cols = 2'd1;
            end
        endcase

        step.fire = fire;
        step.last = beat.last;
        step.cols = (beat.last && (need_next != 2'd0)) ? tail_cols : main_cols;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= 1'b0;
            need_reg <= 2'd0;
        end
        else if (fire)
        begin
            esc_reg  <= beat.last ? 1'b0 : esc_next;
            need_reg <= beat.last ? 2'd0 : need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            lead_reg  <= lead_next;
            held1_reg <= held1_next;
            held2_reg <= held2_next;
            cp_reg    <= cp_next;
        end
    end

endmodule

FILE: rtl/u8dw_accum.sv
module u8dw_accum (
    input  logic            clk,
    input  logic            rst_n,
    input  u8dw_pkg::step_t step,
    output logic            out_free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,  // column_total[15:0]
    output logic            m_tuser   // count_saturated
);
    import u8dw_pkg::*;

    logic [COUNT_BITS-1:0] count_reg;
    logic                  sat_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [15:0]           total_reg;
    logic                  sat_out_reg;

    logic [SUM_BITS-1:0]   sum;
    logic                  hit;
    logic [COUNT_BITS-1:0] count_next;
    logic                  sat_next;

    always_comb
    begin
        sum        = {1'b0, count_reg} + SUM_BITS'(step.cols);
        hit        = (sum >= {1'b0, COUNT_MAX});
        count_next = hit ? COUNT_MAX : sum[COUNT_BITS-1:0];
        sat_next   = sat_reg | hit;

        if (step.fire && step.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = total_reg;
    assign m_tuser  = sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step.fire)
            begin
                count_reg <= step.last ? '0 : count_next;
                sat_reg   <= step.last ? 1'b0 : sat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.fire && step.last)
        begin
            total_reg   <= 16'(count_next);
            sat_out_reg <= sat_next;
        end
    end

endmodule

FILE: rtl/utf8_display_width_counter_unit.sv
// The final byte of a string is accepted into the input register; the result of the string
// then passes through the result register to m_tvalid.
// Throughput: one byte per cycle; the input side stalls only when a final byte meets a
// result register that is full and not being taken.
// Reset: rst_n is asynchronous and active low; it clears the valid flags, the decode state
// and the running count.
module utf8_display_width_counter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // data_byte[7:0]
    input  logic        s_tlast,  // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // column_total[15:0]
    output logic        m_tuser   // count_saturated
);
    import u8dw_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    beat_t in_beat_reg;
    logic  fire;
    logic  out_free;
    step_t step;

    assign fire     = in_valid_reg && (!in_beat_reg.last || out_free);
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_beat_reg.data <= s_tdata;
            in_beat_reg.last <= s_tlast;
        end
    end

    u8dw_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .beat  (in_beat_reg),
        .step  (step)
    );

    u8dw_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/u8dw_checker.sv
module u8dw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);
    import u8dw_pkg::*;

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

    a_out_stay: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A saturated total always shows the maximum count.
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 16'(COUNT_MAX)))
        else $error("saturation flag without a full count");

    // With room for a result the input side is never held off.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although the result register is free");

    // The input payload is observed so that every port is in view.
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !$isunknown({s_tdata, s_tlast}))
        else $error("unknown input beat accepted");

endmodule

bind utf8_display_width_counter_unit u8dw_checker u_checker (.*);
